// ===== src/sprite_quad_vertex_generator_assert.svh =====
// Assertion macros shared by the sprite quad vertex generator RTL.
`ifndef SPRITE_QUAD_VERTEX_GENERATOR_ASSERT_SVH
`define SPRITE_QUAD_VERTEX_GENERATOR_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define SQV_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SQV_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/sqv_pkg.sv =====
// Types, constants and helpers of the sprite quad vertex generator.
`default_nettype none
package sqv_pkg;

  localparam int ANGLE_BITS_DEF   = 16;
  localparam int VERTS_PER_SPRITE = 6;
  localparam int SLOT_W           = 3;
  localparam int CFG_W            = 14;
  localparam int CFG_IDX_W        = 2;

  localparam logic [CFG_IDX_W-1:0] REG_VIEW_W = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_H = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_W  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_H  = 2'd3;

  localparam logic [CFG_W-1:0] RST_VIEW_W = 14'd1280;
  localparam logic [CFG_W-1:0] RST_VIEW_H = 14'd720;
  localparam logic [CFG_W-1:0] RST_TEX_W  = 14'd256;
  localparam logic [CFG_W-1:0] RST_TEX_H  = 14'd256;

  localparam logic [SLOT_W-1:0] SLOT_FIRST = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(VERTS_PER_SPRITE - 1);

  // Q30 sine polynomial coefficients
  localparam int Z_W = 31;
  localparam logic [Z_W-1:0] Q30_ONE = 31'd1073741824;
  localparam logic [Z_W-1:0] SIN_A1  = 31'd1686629713;
  localparam logic [Z_W-1:0] SIN_A3  = 31'd693598669;
  localparam logic [Z_W-1:0] SIN_A5  = 31'd85569306;
  localparam logic [Z_W-1:0] SIN_A7  = 31'd5026995;
  localparam logic [Z_W-1:0] SIN_A9  = 31'd172272;
  localparam int MAG_W   = 17;
  localparam int SIN_LAT = 7;

  // divider: signed numerator, unsigned denominator, clamped quotient
  localparam int NUM_W   = 38;
  localparam int DEN_W   = 19;
  localparam int QUO_W   = 16;
  localparam int DIV_LAT = QUO_W + 1;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0]        size_x;
    logic [15:0]        size_y;
    logic signed [15:0] pivot_x;
    logic signed [15:0] pivot_y;
    logic [15:0]        rotation_angle;
    logic [12:0]        tex_left;
    logic [12:0]        tex_top;
    logic [13:0]        tex_width;
    logic [13:0]        tex_height;
    logic [31:0]        rgba_color;
  } sqv_in_t;

  typedef struct packed {
    logic signed [15:0] ndc_x;
    logic signed [15:0] ndc_y;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic [31:0]        vertex_color;
    logic [2:0]         corner_slot;
    logic               last_vertex;
  } sqv_out_t;

  // per-vertex geometry carried alongside the sine pipes
  typedef struct packed {
    logic signed [17:0] dx;
    logic signed [17:0] dy;
    logic signed [16:0] cx;
    logic signed [16:0] cy;
    logic [14:0]        tu;
    logic [14:0]        tv;
    logic               neg_s;
    logic               neg_c;
  } sqv_geo_t;

  // per-vertex tag carried down the full pipe
  typedef struct packed {
    logic [31:0]       color;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } sqv_tag_t;

  // corner of each slot: 0 TL, 1 TR, 2 BL, 3 BR
  function automatic logic [1:0] slot_corner(input logic [SLOT_W-1:0] slot);
    logic [1:0] c;
    case (slot)
      3'd0:    c = 2'd0;
      3'd1:    c = 2'd1;
      3'd2:    c = 2'd2;
      3'd3:    c = 2'd2;
      3'd4:    c = 2'd1;
      3'd5:    c = 2'd3;
      default: c = 2'd0;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== src/sqv_sine.sv =====
// Pipelined quarter-wave sine polynomial, Q30 fraction in, Q16 magnitude out.
`default_nettype none
module sqv_sine (
  input  wire logic                      clk,
  input  wire logic [sqv_pkg::Z_W-1:0]   z_i,
  output logic      [sqv_pkg::MAG_W-1:0] mag_o
);
  import sqv_pkg::*;

  // p <- a - (p*z2 >> 30)
  function automatic logic [Z_W-1:0] horner(input logic [Z_W-1:0] a,
                                            input logic [Z_W-1:0] p,
                                            input logic [Z_W-1:0] z2);
    logic [2*Z_W-1:0] prod;
    prod = p * z2;
    return a - Z_W'(prod[2*Z_W-1:30]);
  endfunction

  logic [Z_W-1:0]     z_r [1:5];
  logic [Z_W-1:0]     z2_r [1:4];
  logic [Z_W-1:0]     p_r [2:5];
  logic [31:0]        t6_r;
  logic [MAG_W-1:0]   mag_r;
  logic [2*Z_W-1:0]   zz;
  logic [2*Z_W-1:0]   pz;
  logic [31:0]        t_cl;

  assign zz   = z_i * z_i;
  assign pz   = p_r[5] * z_r[5];
  assign t_cl = (t6_r > 32'(Q30_ONE)) ? 32'(Q30_ONE) : t6_r;

  always_ff @(posedge clk) begin
    z_r[1]  <= z_i;
    z2_r[1] <= Z_W'(zz[2*Z_W-1:30]);
    z_r[2]  <= z_r[1];
    z2_r[2] <= z2_r[1];
    p_r[2]  <= horner(SIN_A7, SIN_A9, z2_r[1]);
    z_r[3]  <= z_r[2];
    z2_r[3] <= z2_r[2];
    p_r[3]  <= horner(SIN_A5, p_r[2], z2_r[2]);
    z_r[4]  <= z_r[3];
    z2_r[4] <= z2_r[3];
    p_r[4]  <= horner(SIN_A3, p_r[3], z2_r[3]);
    z_r[5]  <= z_r[4];
    p_r[5]  <= horner(SIN_A1, p_r[4], z2_r[4]);
    t6_r    <= pz[61:30];
    mag_r   <= MAG_W'((t_cl + 32'd8192) >> 14);
  end

  assign mag_o = mag_r;
endmodule
`default_nettype wire

// ===== src/sqv_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, clamped to [0, 2^QUO_W-1].
`default_nettype none
module sqv_div (
  input  wire logic                             clk,
  input  wire logic signed [sqv_pkg::NUM_W-1:0] num_i,
  input  wire logic        [sqv_pkg::DEN_W-1:0] den_i,
  output logic             [sqv_pkg::QUO_W-1:0] quo_o
);
  import sqv_pkg::*;

  localparam int REM_W = DEN_W + QUO_W;

  // den_i must be held steady by the user while items are in flight; the block does not enforce it
  logic [REM_W-1:0] rem_r [0:QUO_W];
  logic [QUO_W-1:0] quo_r [0:QUO_W];
  logic             neg_r [0:QUO_W];
  logic             ovf_r [0:QUO_W];
  logic [NUM_W-1:0] lim;
  logic             neg_in;

  assign lim    = NUM_W'({den_i, {QUO_W{1'b0}}});
  assign neg_in = num_i[NUM_W-1];

  always_ff @(posedge clk) begin
    rem_r[0] <= REM_W'(num_i);
    quo_r[0] <= '0;
    neg_r[0] <= neg_in;
    ovf_r[0] <= !neg_in && ($unsigned(num_i) >= lim);
  end

  for (genvar k = 1; k <= QUO_W; k++) begin : g_stage
    logic [REM_W:0] trial;
    assign trial = {1'b0, rem_r[k-1]} - ((REM_W+1)'(den_i) << (QUO_W - k));
    always_ff @(posedge clk) begin
      rem_r[k] <= trial[REM_W] ? rem_r[k-1] : trial[REM_W-1:0];
      quo_r[k] <= {quo_r[k-1][QUO_W-2:0], !trial[REM_W]};
      neg_r[k] <= neg_r[k-1];
      ovf_r[k] <= ovf_r[k-1];
    end
  end

  assign quo_o = neg_r[QUO_W] ? '0 : (ovf_r[QUO_W] ? '1 : quo_r[QUO_W]);
endmodule
`default_nettype wire

// ===== src/sprite_quad_vertex_generator.sv =====
// Top level: sprite in, six rotated NDC vertices with UVs out.
`default_nettype none
// Sprite quad vertex generator. A sprite is taken when start is high and busy
// is low; its six vertices (TL TR BL BL TR BR) then leave on consecutive
// cycles, each marked by a one-cycle out_valid. The output cannot be held off.
// The vertex issue counter sends one vertex per cycle into a 28-stage pipe
// (sine/cosine polynomial, rotation, four one-bit-per-stage dividers), and
// busy stays high after an accept until that counter reaches the last slot;
// a new sprite may be taken on the cycle its predecessor issues its last
// vertex. Register writes (always ready) are meant for idle times only.
module sprite_quad_vertex_generator #(
  parameter int ANGLE_BITS = sqv_pkg::ANGLE_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire sqv_pkg::sqv_in_t                 in_data,
  output logic                                  out_valid,
  output sqv_pkg::sqv_out_t                     out_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [sqv_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [sqv_pkg::CFG_W-1:0]        cfg_data
);
  import sqv_pkg::*;

  localparam logic [15:0] AMASK = (ANGLE_BITS >= 16) ? 16'hFFFF
                                                     : 16'((1 << ANGLE_BITS) - 1);
  localparam int TAG_DLY = SIN_LAT + 2 + DIV_LAT;

  // ---------------- configuration registers ----------------
  logic [CFG_W-1:0] view_w_r, view_h_r, tex_w_r, tex_h_r;
  logic [CFG_W-1:0] vw_e, vh_e, tw_e, th_e;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_w_r <= RST_VIEW_W;
      view_h_r <= RST_VIEW_H;
      tex_w_r  <= RST_TEX_W;
      tex_h_r  <= RST_TEX_H;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_VIEW_W: view_w_r <= cfg_data;
        REG_VIEW_H: view_h_r <= cfg_data;
        REG_TEX_W:  tex_w_r  <= cfg_data;
        REG_TEX_H:  tex_h_r  <= cfg_data;
        default:    ;
      endcase
    end
  end

  // a zero size acts as one
  assign vw_e = (view_w_r == '0) ? CFG_W'(1) : view_w_r;
  assign vh_e = (view_h_r == '0) ? CFG_W'(1) : view_h_r;
  assign tw_e = (tex_w_r  == '0) ? CFG_W'(1) : tex_w_r;
  assign th_e = (tex_h_r  == '0) ? CFG_W'(1) : tex_h_r;

  // Derived divider constants. Offsets fold the rounding half and a bias so
  // the saturated NDC value becomes a quotient clamped to [0, 65535]:
  //   x: W*16 + 16384*32W,  y: H*16 + 16383*32H.
  logic [NUM_W-1:0] kx_r, ky_r, hu_r, hv_r;
  logic [DEN_W-1:0] den_x_r, den_y_r, den_u_r, den_v_r;

  always_ff @(posedge clk) begin
    kx_r    <= (NUM_W'(vw_e) << 4) + (NUM_W'(vw_e) << 19);
    ky_r    <= (NUM_W'(vh_e) << 4) + (NUM_W'(vh_e) << 19) - (NUM_W'(vh_e) << 5);
    hu_r    <= NUM_W'(tw_e >> 1);
    hv_r    <= NUM_W'(th_e >> 1);
    den_x_r <= DEN_W'({vw_e, 5'b0});
    den_y_r <= DEN_W'({vh_e, 5'b0});
    den_u_r <= DEN_W'(tw_e);
    den_v_r <= DEN_W'(th_e);
  end

  // ---------------- vertex issue ----------------
  sqv_in_t           spr_r;
  logic              act_r, act_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              in_acc;

  assign busy   = act_r && (slot_r != SLOT_LAST);
  assign in_acc = start && !busy;

  always_comb begin
    act_nxt  = act_r;
    slot_nxt = slot_r;
    if (in_acc) begin
      act_nxt  = 1'b1;
      slot_nxt = SLOT_FIRST;
    end else if (act_r) begin
      if (slot_r == SLOT_LAST) begin
        act_nxt = 1'b0;
      end else begin
        slot_nxt = slot_r + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      slot_r <= SLOT_FIRST;
    end else begin
      act_r  <= act_nxt;
      slot_r <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      spr_r <= in_data;
    end
  end

  // ---------------- stage 0: corner, phase fold ----------------
  logic [1:0]         corner;
  logic [31:0]        ph_s, ph_c;
  logic [Z_W-1:0]     z_s, z_c;
  sqv_geo_t           geo0;
  sqv_tag_t           tag0;

  // quarter-wave fold: odd quadrants mirror, upper half negates
  function automatic logic [Z_W-1:0] fold_z(input logic [31:0] ph);
    logic [Z_W-1:0] r;
    r = {1'b0, ph[29:0]};
    return ph[30] ? (Q30_ONE - r) : r;
  endfunction

  always_comb begin
    corner    = slot_corner(slot_r);
    ph_s      = 32'(spr_r.rotation_angle & AMASK) << (32 - ANGLE_BITS);
    ph_c      = ph_s + 32'h4000_0000;
    z_s       = fold_z(ph_s);
    z_c       = fold_z(ph_c);
    geo0.dx   = (corner[0] ? $signed({2'b0, spr_r.size_x}) : 18'sd0)
                - 18'(spr_r.pivot_x);
    geo0.dy   = (corner[1] ? $signed({2'b0, spr_r.size_y}) : 18'sd0)
                - 18'(spr_r.pivot_y);
    geo0.cx   = 17'(spr_r.pos_x) + 17'(spr_r.pivot_x);
    geo0.cy   = 17'(spr_r.pos_y) + 17'(spr_r.pivot_y);
    geo0.tu   = corner[0] ? (15'(spr_r.tex_left) + 15'(spr_r.tex_width))
                          : 15'(spr_r.tex_left);
    geo0.tv   = corner[1] ? (15'(spr_r.tex_top) + 15'(spr_r.tex_height))
                          : 15'(spr_r.tex_top);
    geo0.neg_s = ph_s[31];
    geo0.neg_c = ph_c[31];
    tag0.color = spr_r.rgba_color;
    tag0.slot  = slot_r;
    tag0.last  = (slot_r == SLOT_LAST);
  end

  logic           v0_r;
  logic [Z_W-1:0] zs0_r, zc0_r;
  sqv_geo_t       geo0_r;
  sqv_tag_t       tag0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= act_r;
    end
  end

  always_ff @(posedge clk) begin
    zs0_r  <= z_s;
    zc0_r  <= z_c;
    geo0_r <= geo0;
    tag0_r <= tag0;
  end

  // ---------------- sine and cosine pipes ----------------
  logic [MAG_W-1:0] mag_s, mag_c;

  sqv_sine u_sin (.clk(clk), .z_i(zs0_r), .mag_o(mag_s));
  sqv_sine u_cos (.clk(clk), .z_i(zc0_r), .mag_o(mag_c));

  sqv_geo_t geo_q [0:SIN_LAT-1];

  always_ff @(posedge clk) begin
    geo_q[0] <= geo0_r;
    for (int i = 1; i < SIN_LAT; i++) begin
      geo_q[i] <= geo_q[i-1];
    end
  end

  // ---------------- R1: signs and products ----------------
  sqv_geo_t           ga;
  logic signed [17:0] sv, cv;
  logic signed [35:0] c_dx_r, s_dy_r, s_dx_r, c_dy_r;
  logic [NUM_W-1:0]   cxk_r, cyk_r;
  logic [14:0]        tu1_r, tv1_r;

  assign ga = geo_q[SIN_LAT-1];
  assign sv = ga.neg_s ? -$signed({1'b0, mag_s}) : $signed({1'b0, mag_s});
  assign cv = ga.neg_c ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});

  always_ff @(posedge clk) begin
    c_dx_r <= cv * ga.dx;
    s_dy_r <= sv * ga.dy;
    s_dx_r <= sv * ga.dx;
    c_dy_r <= cv * ga.dy;
    cxk_r  <= (NUM_W'(ga.cx) << 16) + kx_r;
    cyk_r  <= (NUM_W'(ga.cy) << 16) + ky_r;
    tu1_r  <= ga.tu;
    tv1_r  <= ga.tv;
  end

  // ---------------- R2: divider numerators ----------------
  logic signed [NUM_W-1:0] xn_r, yn_r, un_r, vn_r;

  always_ff @(posedge clk) begin
    xn_r <= $signed(cxk_r + NUM_W'(c_dx_r) - NUM_W'(s_dy_r));
    yn_r <= $signed(cyk_r + NUM_W'(s_dx_r) + NUM_W'(c_dy_r));
    un_r <= $signed((NUM_W'(tu1_r) << 15) + hu_r);
    vn_r <= $signed((NUM_W'(tv1_r) << 15) + hv_r);
  end

  // ---------------- dividers ----------------
  logic [QUO_W-1:0] qx, qy, qu, qv;

  sqv_div u_div_x (.clk(clk), .num_i(xn_r), .den_i(den_x_r), .quo_o(qx));
  sqv_div u_div_y (.clk(clk), .num_i(yn_r), .den_i(den_y_r), .quo_o(qy));
  sqv_div u_div_u (.clk(clk), .num_i(un_r), .den_i(den_u_r), .quo_o(qu));
  sqv_div u_div_v (.clk(clk), .num_i(vn_r), .den_i(den_v_r), .quo_o(qv));

  // ---------------- tag and valid delay line ----------------
  sqv_tag_t tag_q [0:TAG_DLY-1];
  logic     vld_q [0:TAG_DLY-1];

  always_ff @(posedge clk) begin
    tag_q[0] <= tag0_r;
    for (int i = 1; i < TAG_DLY; i++) begin
      tag_q[i] <= tag_q[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAG_DLY; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else begin
      vld_q[0] <= v0_r;
      for (int i = 1; i < TAG_DLY; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  // ---------------- output register ----------------
  // x quotient is biased by 32768, y quotient maps as 32767 - q
  logic     out_valid_r;
  sqv_out_t out_data_r;
  sqv_tag_t tz;

  assign tz = tag_q[TAG_DLY-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_q[TAG_DLY-1];
    end
  end

  always_ff @(posedge clk) begin
    out_data_r.ndc_x        <= $signed(qx ^ 16'h8000);
    out_data_r.ndc_y        <= $signed(16'h7FFF - qy);
    out_data_r.tex_u        <= qu;
    out_data_r.tex_v        <= qv;
    out_data_r.vertex_color <= tz.color;
    out_data_r.corner_slot  <= tz.slot;
    out_data_r.last_vertex  <= tz.last;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------- checks ----------------
  `include "sprite_quad_vertex_generator_assert.svh"

  `SQV_ASSERT_NEXT(a_first_issue, clk, rst_n, in_acc, act_r && (slot_r == SLOT_FIRST), "accepted sprite did not start at the first slot")
  `SQV_ASSERT_IMPLY(a_last_mark, clk, rst_n, out_valid, out_data.last_vertex == (out_data.corner_slot == SLOT_LAST), "last flag out of step with slot")
  `SQV_ASSERT_IMPLY(a_burst, clk, rst_n, out_valid && (out_data.corner_slot != SLOT_FIRST), $past(out_valid), "gap inside a vertex burst")
  `SQV_ASSERT_NEXT(a_after_last, clk, rst_n, out_valid && out_data.last_vertex, !out_valid || (out_data.corner_slot == SLOT_FIRST), "vertex after last did not start a new sprite")

endmodule
`default_nettype wire
